/* rtl/core/bffa_pkg.sv */
// shared constants and codes of the first-free bitmap allocator
`timescale 1ns / 1ps

package bffa_pkg;

    // fixed field widths
    localparam int NUM_W    = 14;
    localparam int STATUS_W = 2;

    // default geometry of the bitmap
    localparam int DEFAULT_MAP_BITS  = 8192;
    localparam int DEFAULT_WORD_BITS = 32;

    // entry count after reset
    localparam logic [NUM_W-1:0] ENTRY_COUNT_RST = NUM_W'(8192);

    // request kinds
    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

endpackage

/* rtl/core/bitmap_first_free_allocator_top.sv */
// first-free bitmap allocator with the bitmap held in a synchronous memory
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------------
// s        | in        | s_tvalid/s_tready  | tdata: entry_number; tuser: operation
// m        | out       | m_tvalid/m_tready  | tdata: allocated_number, free_count; tuser: status
// cfg      | in        | cfg_wr_en          | cfg_wr_data: entry_count
//
// a free request passes IDLE, FREE and DONE before the next acceptance, or IDLE and DONE
// when its number is out of range; an allocate request passes IDLE, a SCAN step per word
// read from the search start (one word per cycle, single read port) and DONE, or IDLE and
// DONE when no word is left to search; DONE waits until the output register can take the result
// a start-word register keeps the search from re-reading words known to be full
// after reset a clearing pass writes zeros to every word before the first request is taken;
// configuration writes are taken always
// a finished result waits in the output register while the next request is taken
// WORD_BITS must be a power of two
`timescale 1ns / 1ps

module bitmap_first_free_allocator_top #(
    parameter int MAP_BITS  = bffa_pkg::DEFAULT_MAP_BITS,
    parameter int WORD_BITS = bffa_pkg::DEFAULT_WORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [bffa_pkg::NUM_W-1:0] cfg_wr_data,
    // request stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // [13:0] entry_number, [15:14] zero
    input  logic [0:0]                s_tuser,   // [0] operation
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // [13:0] allocated_number,
                                                 // [27:14] free_count, [31:28] zero
    output logic [1:0]                m_tuser    // [1:0] status
);

    import bffa_pkg::*;

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WLOG      = $clog2(WORD_BITS);
    localparam int HW        = AW + 1;

    typedef enum logic [4:0]
    {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FREE  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // control state
    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [HW-1:0]      hint_reg, hint_next;
    logic [NUM_W-1:0]   used_reg, used_next;
    logic [NUM_W-1:0]   entry_count_reg;
    logic               m_tvalid_reg, m_tvalid_next;

    // working and result payload
    logic [AW-1:0]      word_addr_reg, word_addr_next;
    logic [WLOG-1:0]    bit_sel_reg, bit_sel_next;
    logic [NUM_W-1:0]   alloc_num_reg, alloc_num_next;
    status_t            status_reg, status_next;
    logic [NUM_W-1:0]   out_alloc_reg;
    logic [NUM_W-1:0]   out_free_reg;
    status_t            out_status_reg;

    // memory ports
    logic [WORD_BITS-1:0] bitmap_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] mem_rd_reg;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_wa, mem_ra;
    logic [WORD_BITS-1:0] mem_wd;

    // derived values
    logic [NUM_W-1:0]     eff_count;
    logic [NUM_W-1:0]     eff_m1;
    logic [31:0]          last_word;
    logic [NUM_W-1:0]     req_num;
    logic [NUM_W-1:0]     req_idx;
    logic [31:0]          req_word;
    logic                 in_accept;
    logic                 out_load;
    logic                 is_last;
    logic [WORD_BITS-1:0] avail;
    logic                 found;
    logic [WLOG-1:0]      found_pos;
    logic [31:0]          found_idx;
    logic [NUM_W-1:0]     free_calc;

    // effective entry count, clamped to the bitmap size
    always_comb
    begin
        if (32'(entry_count_reg) > MAP_BITS)
            eff_count = NUM_W'(MAP_BITS);
        else
            eff_count = entry_count_reg;
        eff_m1    = eff_count - NUM_W'(1);
        last_word = 32'(eff_m1) >> WLOG;
    end

    // request fields and handshakes
    assign req_num   = s_tdata[NUM_W-1:0];
    assign req_idx   = req_num - NUM_W'(1);
    assign req_word  = 32'(req_idx) >> WLOG;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // usable clear bits of the word under scan
    assign is_last = (32'(word_addr_reg) == last_word);

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            avail[b] = !mem_rd_reg[b] && (!is_last || (WLOG'(b) <= eff_m1[WLOG-1:0]));
        end
    end

    // lowest usable clear bit
    always_comb
    begin
        found     = 1'b0;
        found_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                found     = 1'b1;
                found_pos = WLOG'(b);
            end
        end
    end

    assign found_idx = ((32'(word_addr_reg) << WLOG) | 32'(found_pos)) + 32'd1;

    // free entries after the request
    assign free_calc = (used_reg >= eff_count) ? '0 : (eff_count - used_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        hint_next      = hint_reg;
        used_next      = used_reg;
        word_addr_next = word_addr_reg;
        bit_sel_next   = bit_sel_reg;
        alloc_num_next = alloc_num_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_wa         = word_addr_reg;
        mem_wd         = mem_rd_reg;
        mem_re         = 1'b0;
        mem_ra         = word_addr_reg;

        case (state_reg)
            // zero the bitmap one word a cycle
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                mem_wd = '0;
                if (clr_addr_reg == AW'(MAP_WORDS - 1))
                    state_next = S_IDLE;
                else
                    clr_addr_next = clr_addr_reg + AW'(1);
            end

            // take a request and start its word read
            S_IDLE:
            begin
                if (in_accept)
                begin
                    alloc_num_next = '0;
                    if (s_tuser[0] == OP_FREE)
                    begin
                        if (req_num == '0 || req_num > eff_count)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            word_addr_next = req_word[AW-1:0];
                            bit_sel_next   = req_idx[WLOG-1:0];
                            mem_re         = 1'b1;
                            mem_ra         = req_word[AW-1:0];
                            state_next     = S_FREE;
                        end
                    end
                    else
                    begin
                        if (eff_count == '0 || 32'(hint_reg) > last_word)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            word_addr_next = hint_reg[AW-1:0];
                            mem_re         = 1'b1;
                            mem_ra         = hint_reg[AW-1:0];
                            state_next     = S_SCAN;
                        end
                    end
                end
            end

            // look at one word, claim a bit or move on
            S_SCAN:
            begin
                if (found)
                begin
                    mem_we         = 1'b1;
                    mem_wd         = mem_rd_reg | (WORD_BITS'(1) << found_pos);
                    used_next      = used_reg + NUM_W'(1);
                    hint_next      = HW'(word_addr_reg);
                    alloc_num_next = found_idx[NUM_W-1:0];
                    status_next    = ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    if (&mem_rd_reg)
                        hint_next = HW'(word_addr_reg) + HW'(1);
                    if (is_last)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        word_addr_next = word_addr_reg + AW'(1);
                        mem_re         = 1'b1;
                        mem_ra         = word_addr_reg + AW'(1);
                    end
                end
            end

            // clear the addressed bit if it is set
            S_FREE:
            begin
                status_next = ST_OK;
                state_next  = S_DONE;
                if (mem_rd_reg[bit_sel_reg])
                begin
                    mem_we = 1'b1;
                    mem_wd = mem_rd_reg & ~(WORD_BITS'(1) << bit_sel_reg);
                    if (used_reg != '0)
                        used_next = used_reg - NUM_W'(1);
                    if (HW'(word_addr_reg) < hint_reg)
                        hint_next = HW'(word_addr_reg);
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            hint_reg        <= '0;
            used_reg        <= '0;
            entry_count_reg <= ENTRY_COUNT_RST;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            hint_reg     <= hint_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
                entry_count_reg <= cfg_wr_data;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        word_addr_reg <= word_addr_next;
        bit_sel_reg   <= bit_sel_next;
        alloc_num_reg <= alloc_num_next;
        status_reg    <= status_next;
        if (out_load)
        begin
            out_alloc_reg  <= alloc_num_reg;
            out_status_reg <= status_reg;
            out_free_reg   <= free_calc;
        end
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bitmap_mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_rd_reg <= bitmap_mem[mem_ra];
    end

    // result stream
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_free_reg, out_alloc_reg};
    assign m_tuser  = out_status_reg;

endmodule
